FILE: rtl/rhht_pkg.sv
package rhht_pkg;

	// table geometry and field widths
	localparam int SLOT_COUNT = 1024;
	localparam int ADDR_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int HASH_W      = 32;
	localparam int DIST_W      = 15;

	localparam logic [DIST_W-1:0] PROBE_CAP  = {DIST_W{1'b1}};
	localparam logic [HASH_W-1:0] HASH_MULT  = 32'h9e3779b9;
	localparam logic [CNT_W-1:0]  BC_RESET   = CNT_W'(1021);
	localparam logic [CNT_W-1:0]  BC_MIN     = CNT_W'(2);
	localparam logic [CNT_W-1:0]  BC_MAX     = CNT_W'(SLOT_COUNT);
	localparam int LOAD_NUM = 15;
	localparam int LOAD_DEN_SHIFT = 4;

	// stream widths
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 64;

	// operation codes
	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		STS_OK          = 2'd0,
		STS_NOT_FOUND   = 2'd1,
		STS_LOAD_FULL   = 2'd2,
		STS_PROBE_LIMIT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_READ,
		ST_EVAL,
		ST_RESP
	} state_t;

	// one bucket of the table
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
		logic [VAL_W-1:0]  value;
		logic [DIST_W-1:0] plen;
		logic              tomb;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic accept;
		logic div_start;
		logic early_en;
		logic home_en;
		logic ev_en;
		logic resp_en;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic early_done;
		logic ev_done;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/rhht_div.sv
module rhht_div import rhht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [ADDR_W-1:0] rem
);

	localparam int STEP_W = $clog2(HASH_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [HASH_W-1:0] dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, dvd_q[HASH_W-1]};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and shifting dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= diff[CNT_W-1:0];
			else
				rem_q <= trial[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[ADDR_W-1:0];

endmodule

FILE: rtl/rhht_dp.sv
module rhht_dp import rhht_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_wr_en,
	input  logic [CNT_W-1:0]    cfg_wr_data
);

	slot_t             mem [SLOT_COUNT];
	slot_t             rd_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	slot_t             wr_data;

	logic [ADDR_W-1:0] clr_cnt_q;
	logic [CNT_W-1:0]  bc_q;
	logic [CNT_W-1:0]  live_q;
	logic [1:0]        func_q;
	logic [KEY_W-1:0]  key_q;
	logic [HASH_W-1:0] hash_q;
	logic [VAL_W-1:0]  val_q;
	logic [DIST_W-1:0] probes_q;
	logic [ADDR_W-1:0] bucket_q;

	status_t           res_sts_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [DIST_W-1:0] res_fp_q;
	logic              out_vld_q;
	logic [M_DATA_W-1:0] out_q;

	logic              div_done;
	logic [ADDR_W-1:0] div_rem;
	logic [CNT_W-1:0]  load_limit;
	logic [CNT_W+3:0]  load_prod;
	logic [CNT_W-1:0]  cfg_clamped;
	logic [CNT_W-1:0]  bucket_inc;
	logic [HASH_W-1:0] key_hash;

	logic              match;
	logic              ev_wr;
	slot_t             ev_wdata;
	logic              ev_done;
	status_t           ev_sts;
	logic [VAL_W-1:0]  ev_val;
	logic [DIST_W-1:0] ev_fp;
	logic              live_inc;
	logic              live_dec;
	logic              swap;
	logic [DIST_W-1:0] adv_base;
	logic              early_done;
	status_t           early_sts;
	slot_t             new_slot;

	// home bucket divider
	rhht_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (hash_q),
		.divisor  (bc_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// hash of the incoming key, config clamp, load limit and next probe bucket
	always_comb begin
		key_hash = s_tdata[33:2] * HASH_MULT;
		if (cfg_wr_data < BC_MIN)
			cfg_clamped = BC_MIN;
		else if (cfg_wr_data > BC_MAX)
			cfg_clamped = BC_MAX;
		else
			cfg_clamped = cfg_wr_data;
		load_prod  = {4'b0, bc_q} * (CNT_W+4)'(LOAD_NUM);
		load_limit = load_prod[CNT_W+LOAD_DEN_SHIFT-1:LOAD_DEN_SHIFT];
		bucket_inc = {1'b0, bucket_q} + 1'b1;
		if (bucket_inc >= bc_q)
			bucket_inc = '0;
	end

	// checks made before any probing
	always_comb begin
		early_done = 1'b0;
		early_sts  = STS_NOT_FOUND;
		case (func_q)
			FN_LOOKUP, FN_REMOVE: early_done = 1'b0;
			FN_INSERT: begin
				if (live_q >= load_limit) begin
					early_done = 1'b1;
					early_sts  = STS_LOAD_FULL;
				end
			end
			default: early_done = 1'b1;
		endcase
	end

	// one probe step: decide on the bucket just read
	always_comb begin
		new_slot = '{key: key_q, hash: hash_q, value: val_q, plen: probes_q, tomb: 1'b0};
		match    = !rd_q.tomb && (rd_q.hash == hash_q) && (rd_q.key == key_q);
		ev_wr    = 1'b0;
		ev_wdata = rd_q;
		ev_done  = 1'b0;
		ev_sts   = STS_OK;
		ev_val   = '0;
		ev_fp    = '0;
		live_inc = 1'b0;
		live_dec = 1'b0;
		swap     = 1'b0;
		adv_base = probes_q;
		if (func_q == FN_INSERT) begin
			if (rd_q.plen == '0) begin
				ev_wr    = 1'b1;
				ev_wdata = new_slot;
				live_inc = 1'b1;
				ev_done  = 1'b1;
			end else if (match) begin
				ev_wr          = 1'b1;
				ev_wdata.value = val_q;
				ev_fp          = rd_q.plen;
				ev_done        = 1'b1;
			end else if (rd_q.plen < probes_q) begin
				ev_wr    = 1'b1;
				ev_wdata = new_slot;
				if (rd_q.tomb) begin
					live_inc = 1'b1;
					ev_done  = 1'b1;
				end else begin
					swap     = 1'b1;
					adv_base = rd_q.plen;
				end
			end
		end else begin
			if (rd_q.plen == '0 || probes_q > rd_q.plen) begin
				ev_done = 1'b1;
				ev_sts  = STS_NOT_FOUND;
			end else if (match) begin
				ev_done = 1'b1;
				ev_val  = rd_q.value;
				ev_fp   = rd_q.plen;
				if (func_q == FN_REMOVE) begin
					ev_wr         = 1'b1;
					ev_wdata.tomb = 1'b1;
					live_dec      = 1'b1;
				end
			end
		end
		if (!ev_done && adv_base == PROBE_CAP) begin
			ev_done = 1'b1;
			ev_sts  = STS_PROBE_LIMIT;
		end
	end

	// table memory, shared write port for clearing and updates
	always_comb begin
		wr_en   = cmd.clr_en || (cmd.ev_en && ev_wr);
		wr_addr = cmd.clr_en ? clr_cnt_q : bucket_q;
		wr_data = cmd.clr_en ? slot_t'('0) : ev_wdata;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[bucket_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			bc_q      <= BC_RESET;
			live_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.clr_en)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cfg_wr_en)
				bc_q <= cfg_clamped;
			if (cmd.ev_en && live_inc)
				live_q <= live_q + 1'b1;
			else if (cmd.ev_en && live_dec && live_q != '0)
				live_q <= live_q - 1'b1;
			if (cmd.resp_en)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	// working item and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q    <= s_tdata[1:0];
			key_q     <= s_tdata[33:2];
			val_q     <= s_tdata[65:34];
			hash_q    <= key_hash;
			res_sts_q <= STS_OK;
			res_val_q <= '0;
			res_fp_q  <= '0;
		end
		if (cmd.early_en)
			res_sts_q <= early_sts;
		if (cmd.home_en) begin
			bucket_q <= div_rem;
			probes_q <= DIST_W'(1);
		end
		if (cmd.ev_en) begin
			if (ev_done) begin
				res_sts_q <= ev_sts;
				res_val_q <= ev_val;
				res_fp_q  <= ev_fp;
			end else begin
				bucket_q <= bucket_inc[ADDR_W-1:0];
				probes_q <= adv_base + 1'b1;
				if (swap) begin
					key_q  <= rd_q.key;
					hash_q <= rd_q.hash;
					val_q  <= rd_q.value;
				end
			end
		end
		if (cmd.resp_en)
			out_q <= {4'b0, live_q, res_fp_q, res_val_q, res_sts_q};
	end

	always_comb begin
		sts.clr_done   = (clr_cnt_q == ADDR_W'(SLOT_COUNT - 1));
		sts.div_done   = div_done;
		sts.early_done = early_done;
		sts.ev_done    = ev_done;
		sts.out_free   = !out_vld_q || m_tready;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= BC_MAX)
		else $error("live count above table size");
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_en |-> ({1'b0, bucket_q} < bc_q))
		else $error("probe bucket outside table");
	a_home_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ({1'b0, div_rem} < bc_q))
		else $error("home bucket not below bucket count");
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_en |-> (!out_vld_q || m_tready))
		else $error("result register overwritten");
`endif

endmodule

FILE: rtl/rhht_ctrl.sv
module rhht_ctrl import rhht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (s_tvalid) state_d = ST_START;
			ST_START: state_d = sts.early_done ? ST_RESP : ST_DIV;
			ST_DIV:   if (sts.div_done) state_d = ST_READ;
			ST_READ:  state_d = ST_EVAL;
			ST_EVAL:  state_d = sts.ev_done ? ST_RESP : ST_READ;
			ST_RESP:  if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_en = 1'b1;
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_START: begin
				cmd.early_en  = sts.early_done;
				cmd.div_start = !sts.early_done;
			end
			ST_DIV:  cmd.home_en = sts.div_done;
			ST_READ: cmd = '0;
			ST_EVAL: cmd.ev_en = 1'b1;
			ST_RESP: cmd.resp_en = sts.out_free;
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction taken while busy");
	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_en |-> $past(state_q) == ST_READ)
		else $error("probe evaluated without a read");
	a_resp_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_en |=> !cmd.resp_en)
		else $error("result loaded twice");
`endif

endmodule

FILE: rtl/robin_hood_hash_table.sv
// Robin Hood hash table with linear probing, up to 1024 buckets.
// Input stream s_*: one transaction is one request (lookup, insert, remove).
// Output stream m_*: exactly one result transaction per request, in order.
// cfg_wr_en/cfg_wr_data write bucket_count (clamped to 2..1024); write it
// only while the block is idle and the table is empty.
// After reset the block clears the distance and tombstone of every bucket,
// one bucket per cycle; s_tready stays low meanwhile.
// Steps: take the request and hash the key, a setup step (load check),
// the home bucket (bit-serial remainder by bucket_count), then for each
// bucket probed a memory read, then compare and update, and last the load
// into the output register.
// Requests are handled one at a time; a new request is taken as soon as the
// previous result sits in the output register.
// If m_tready is low the result waits in the output register; the block can
// take and finish one more request, which then waits until that register
// frees, and s_tready stays low until the waiting result is delivered.
module robin_hood_hash_table import rhht_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // func[1:0], key_in[33:2], value_in[65:34]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // status[1:0], value_out[33:2],
	                                       // found_probes[48:34], item_count[59:49]
	input  logic                cfg_wr_en,
	input  logic [CNT_W-1:0]    cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	rhht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rhht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

endmodule
